### sv/spx_pkg.sv
// Shared types, constants and sub-tile offset tables for the sprite entry tile expander.
// No dependencies.
package spx_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam int CODE_W = 14;
    localparam int POS_W  = 9;

    typedef enum logic [2:0] {
        K_ONE    = 3'd0,
        K_LINE_H = 3'd1,
        K_LINE_V = 3'd2,
        K_SQ32   = 3'd3,
        K_WIDE   = 3'd4,
        K_TALL   = 3'd5,
        K_SQ64   = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    // One classified entry, as it waits in the queue.
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [3:0]        colour;
        logic [1:0]        flip;   // {flip y, flip x}
        t_kind             kind;
        logic [3:0]        last;   // sub-tile count minus one
    } t_desc;

    // Queue head as seen by the back end.
    typedef struct packed {
        logic  valid;
        t_desc desc;
    } t_head;

    typedef struct packed {
        logic [3:0] off;
        logic [1:0] dx;
        logic [1:0] dy;
    } t_sub;

    // Code offsets, indexed by {flip y, flip x} then by sub-tile number.
    localparam logic [3:0] OFF_SQ32 [4][4] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3},
        '{4'd1, 4'd0, 4'd3, 4'd2},
        '{4'd2, 4'd3, 4'd0, 4'd1},
        '{4'd3, 4'd2, 4'd1, 4'd0}
    };
    localparam logic [3:0] OFF_TALL [4][8] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7},
        '{4'd5, 4'd4, 4'd7, 4'd6, 4'd1, 4'd0, 4'd3, 4'd2},
        '{4'd2, 4'd3, 4'd0, 4'd1, 4'd6, 4'd7, 4'd4, 4'd5},
        '{4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0}
    };
    localparam logic [3:0] OFF_WIDE [4][8] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7},
        '{4'd1, 4'd0, 4'd3, 4'd2, 4'd5, 4'd4, 4'd7, 4'd6},
        '{4'd6, 4'd7, 4'd4, 4'd5, 4'd2, 4'd3, 4'd0, 4'd1},
        '{4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0}
    };
    localparam logic [3:0] OFF_SQ64 [4][16] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
          4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
        '{4'd5, 4'd4, 4'd7, 4'd6, 4'd1, 4'd0, 4'd3, 4'd2,
          4'd13, 4'd12, 4'd15, 4'd14, 4'd9, 4'd8, 4'd11, 4'd10},
        '{4'd10, 4'd11, 4'd8, 4'd9, 4'd14, 4'd15, 4'd12, 4'd13,
          4'd2, 4'd3, 4'd0, 4'd1, 4'd6, 4'd7, 4'd4, 4'd5},
        '{4'd15, 4'd14, 4'd13, 4'd12, 4'd11, 4'd10, 4'd9, 4'd8,
          4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0}
    };

    // Code offset and 16-pixel position step of sub-tile idx.
    // Square layouts interleave: x from idx bits 2,0 and y from idx bits 3,1.
    function automatic t_sub sub_tile(t_kind kind, logic [1:0] flip,
                                      logic [3:0] last, logic [3:0] idx);
        t_sub       s;
        logic [3:0] k;
        s = '0;
        k = idx;
        unique case (kind)
            K_ONE: begin
                s = '0;
            end
            K_LINE_H: begin
                k     = flip[0] ? (last - idx) : idx;
                s.off = k;
                s.dx  = k[1:0];
            end
            K_LINE_V: begin
                k     = flip[1] ? (last - idx) : idx;
                s.off = k;
                s.dy  = k[1:0];
            end
            K_SQ32: begin
                s.off = OFF_SQ32[flip][idx[1:0]];
                s.dx  = {1'b0, idx[0]};
                s.dy  = {1'b0, idx[1]};
            end
            K_WIDE: begin
                s.off = OFF_WIDE[flip][idx[2:0]];
                s.dx  = {idx[2], idx[0]};
                s.dy  = {1'b0, idx[1]};
            end
            K_TALL: begin
                s.off = OFF_TALL[flip][idx[2:0]];
                s.dx  = {1'b0, idx[0]};
                s.dy  = idx[2:1];
            end
            K_SQ64: begin
                s.off = OFF_SQ64[flip][idx];
                s.dx  = {idx[2], idx[0]};
                s.dy  = {idx[3], idx[1]};
            end
            default: begin
                s = '0;
            end
        endcase
        return s;
    endfunction

endpackage

### sv/spx_front.sv
// Front end: takes an entry, filters on visibility and pass, classifies the size.
// Depends on spx_pkg.
module spx_front
    import spx_pkg::*;
(
    input  logic       start,
    input  logic       i_full,
    input  logic [3:0] i_pass_priority,
    input  logic [7:0] i_attr_byte,
    input  logic [7:0] i_code_low_byte,
    input  logic [7:0] i_code_high_byte,
    input  logic [7:0] i_size_color_byte,
    input  logic [7:0] i_y_low_byte,
    input  logic [7:0] i_y_high_byte,
    input  logic [7:0] i_x_low_byte,
    input  logic [7:0] i_x_high_byte,
    output logic       o_push,
    output t_desc      o_desc
);

    logic size_ok;
    logic show;

    always_comb begin
        size_ok       = 1'b1;
        o_desc.kind   = K_ONE;
        o_desc.last   = 4'd0;
        unique case (i_size_color_byte[3:0])
            4'd5:  begin o_desc.kind = K_ONE;    o_desc.last = 4'd0;  end
            4'd6:  begin o_desc.kind = K_LINE_H; o_desc.last = 4'd1;  end
            4'd7:  begin o_desc.kind = K_LINE_H; o_desc.last = 4'd3;  end
            4'd9:  begin o_desc.kind = K_LINE_V; o_desc.last = 4'd1;  end
            4'd13: begin o_desc.kind = K_LINE_V; o_desc.last = 4'd3;  end
            4'd10: begin o_desc.kind = K_SQ32;   o_desc.last = 4'd3;  end
            4'd11: begin o_desc.kind = K_WIDE;   o_desc.last = 4'd7;  end
            4'd14: begin o_desc.kind = K_TALL;   o_desc.last = 4'd7;  end
            4'd15: begin o_desc.kind = K_SQ64;   o_desc.last = 4'd15; end
            default: begin
                size_ok = 1'b0;   // any 8-pixel side
            end
        endcase
        o_desc.code   = {i_code_high_byte, i_code_low_byte[7:2]};
        o_desc.x      = {i_x_high_byte[0], i_x_low_byte};
        o_desc.y      = {i_y_high_byte[0], i_y_low_byte};
        o_desc.colour = i_size_color_byte[7:4];
        o_desc.flip   = i_attr_byte[1:0];
    end

    assign show   = i_attr_byte[2] && (i_attr_byte[7:4] == i_pass_priority) && size_ok;
    assign o_push = start && !i_full && show;

endmodule

### sv/spx_queue.sv
// Short queue of classified entries between front and back end.
// Depends on spx_pkg.
module spx_queue
    import spx_pkg::*;
#(
    parameter int Depth = QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    input  logic  i_pop,
    output t_head o_head,
    output logic  o_full
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(Depth);

    t_desc           r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count, n_count;
    logic            do_pop;

    assign do_pop = i_pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PtrLast) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrLast) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.desc  = r_mem[r_rd_ptr];
    assign o_full       = (r_count == CntFull);

endmodule

### sv/spx_back.sv
// Back end: walks the sub-tiles of one entry, one registered tile command per cycle.
// Depends on spx_pkg.
module spx_back
    import spx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_head       i_head,
    output logic        o_pop,
    output logic        o_strobe,
    output logic [14:0] o_tile_code,
    output logic [9:0]  o_pos_x,
    output logic [9:0]  o_pos_y,
    output logic [3:0]  o_colour,
    output logic        o_mirror_x,
    output logic        o_mirror_y,
    output logic        o_last_tile
);

    t_state      r_state, n_state;
    t_desc       r_desc;
    logic [3:0]  r_idx, n_idx;
    logic        at_last;
    t_sub        sub;

    logic        r_strobe;
    logic [14:0] r_code;
    logic [9:0]  r_px, r_py;
    logic [3:0]  r_col;
    logic        r_fx, r_fy, r_last;

    assign at_last = (r_idx == r_desc.last);
    assign sub     = sub_tile(r_desc.kind, r_desc.flip, r_desc.last, r_idx);
    // next entry is taken on the cycle the current one ends
    assign o_pop   = i_head.valid && ((r_state == ST_IDLE) || at_last);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    n_state = ST_RUN;
                    n_idx   = '0;
                end
            end
            ST_RUN: begin
                if (at_last) begin
                    n_state = o_pop ? ST_RUN : ST_IDLE;
                    n_idx   = '0;
                end else begin
                    n_idx   = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_idx   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_idx    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_strobe <= (r_state == ST_RUN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_desc <= i_head.desc;
        end
        r_code <= {1'b0, r_desc.code} + {11'd0, sub.off};
        r_px   <= {1'b0, r_desc.x} + {4'd0, sub.dx, 4'd0};
        r_py   <= {1'b0, r_desc.y} + {4'd0, sub.dy, 4'd0};
        r_col  <= r_desc.colour;
        r_fx   <= r_desc.flip[0];
        r_fy   <= r_desc.flip[1];
        r_last <= at_last;
    end

    assign o_strobe    = r_strobe;
    assign o_tile_code = r_code;
    assign o_pos_x     = r_px;
    assign o_pos_y     = r_py;
    assign o_colour    = r_col;
    assign o_mirror_x  = r_fx;
    assign o_mirror_y  = r_fy;
    assign o_last_tile = r_last;

endmodule

### sv/sprite_entry_tile_expander.sv
// Top level of the sprite entry tile expander: front end, entry queue, back end.
// Depends on spx_pkg, spx_front, spx_queue, spx_back.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------------------------
//  entry in | start, busy             | i_pass_priority, i_attr_byte, i_*_byte
//  tile out | o_strobe (no backpress) | o_tile_code, o_pos_x/y, o_colour, o_mirror_*,
//           |                         | o_last_tile
//
// An entry transfers on a clock edge with start high and busy low. Hidden
// entries, entries of another pass and sizes with an 8-pixel side are dropped
// on the spot. A kept entry is written into the entry queue, taken into the
// back end's descriptor register when popped, and then gives one tile command
// per cycle through the output registers: 1, 2, 4, 8 or 16 commands; the back
// end sequencer steps through the sub-tiles, and queued entries follow
// without a gap. busy is high while the entry queue is full; the receiver
// never stalls. Reset is synchronous and active low.
module sprite_entry_tile_expander
    import spx_pkg::*;
#(
    parameter int QueueDepth = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  i_pass_priority,
    input  logic [7:0]  i_attr_byte,
    input  logic [7:0]  i_code_low_byte,
    input  logic [7:0]  i_code_high_byte,
    input  logic [7:0]  i_size_color_byte,
    input  logic [7:0]  i_y_low_byte,
    input  logic [7:0]  i_y_high_byte,
    input  logic [7:0]  i_x_low_byte,
    input  logic [7:0]  i_x_high_byte,
    output logic        o_strobe,
    output logic [14:0] o_tile_code,
    output logic [9:0]  o_pos_x,
    output logic [9:0]  o_pos_y,
    output logic [3:0]  o_colour,
    output logic        o_mirror_x,
    output logic        o_mirror_y,
    output logic        o_last_tile
);

    logic  push;
    logic  pop;
    logic  full;
    t_desc desc;
    t_head head;

    // decode and filter; only kept entries enter the queue
    spx_front u_front (
        .start             (start),
        .i_full            (full),
        .i_pass_priority   (i_pass_priority),
        .i_attr_byte       (i_attr_byte),
        .i_code_low_byte   (i_code_low_byte),
        .i_code_high_byte  (i_code_high_byte),
        .i_size_color_byte (i_size_color_byte),
        .i_y_low_byte      (i_y_low_byte),
        .i_y_high_byte     (i_y_high_byte),
        .i_x_low_byte      (i_x_low_byte),
        .i_x_high_byte     (i_x_high_byte),
        .o_push            (push),
        .o_desc            (desc)
    );

    // decouples intake from tile emission
    spx_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (desc),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full)
    );

    // sub-tile sequencer with registered command outputs
    spx_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .o_strobe    (o_strobe),
        .o_tile_code (o_tile_code),
        .o_pos_x     (o_pos_x),
        .o_pos_y     (o_pos_y),
        .o_colour    (o_colour),
        .o_mirror_x  (o_mirror_x),
        .o_mirror_y  (o_mirror_y),
        .o_last_tile (o_last_tile)
    );

    // intake stops only on a full queue
    assign busy = full;

endmodule

### sv/spx_checker.sv
// Port-level checks for the sprite entry tile expander, bound to the top level.
// Depends on sprite_entry_tile_expander.
module spx_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        busy,
    input logic        o_strobe,
    input logic [14:0] o_tile_code,
    input logic [9:0]  o_pos_x,
    input logic [9:0]  o_pos_y,
    input logic [3:0]  o_colour,
    input logic        o_mirror_x,
    input logic        o_mirror_y,
    input logic        o_last_tile
);

    // reset clears the queue and the sequencer
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_strobe)
        else $error("busy or strobe high after reset");

    // an entry's commands come out in consecutive cycles
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last_tile |=> o_strobe)
        else $error("gap inside a tile burst");

    // colour and flips are per entry
    a_entry_attr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last_tile |=>
            $stable(o_colour) && $stable(o_mirror_x) && $stable(o_mirror_y))
        else $error("entry attributes changed mid burst");

    // consecutive sub-tiles of one entry never repeat a code
    a_code_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last_tile |=> o_tile_code != $past(o_tile_code))
        else $error("repeated tile code inside a burst");

    // nor a position
    a_pos_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last_tile |=>
            (o_pos_x != $past(o_pos_x)) || (o_pos_y != $past(o_pos_y)))
        else $error("repeated tile position inside a burst");

endmodule

bind sprite_entry_tile_expander spx_checker u_spx_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .busy        (busy),
    .o_strobe    (o_strobe),
    .o_tile_code (o_tile_code),
    .o_pos_x     (o_pos_x),
    .o_pos_y     (o_pos_y),
    .o_colour    (o_colour),
    .o_mirror_x  (o_mirror_x),
    .o_mirror_y  (o_mirror_y),
    .o_last_tile (o_last_tile)
);

### verif/sprite_entry_tile_expander_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for sprite_entry_tile_expander: directed and random sprite entries,
// each expanded by a local tile-command predictor and checked against the o_strobe stream.
// Depends on spx_pkg (t_kind) and the RTL of sprite_entry_tile_expander.

import spx_pkg::*;

// Raw sprite-list entry as it sits on the input ports.
typedef struct packed {
    logic [3:0] pass_pri;
    logic [7:0] attr;
    logic [7:0] code_lo;
    logic [7:0] code_hi;
    logic [7:0] size_color;
    logic [7:0] y_lo;
    logic [7:0] y_hi;
    logic [7:0] x_lo;
    logic [7:0] x_hi;
} t_entry;

// One 16x16 tile draw command.
typedef struct packed {
    logic [14:0] code;
    logic [9:0]  x;
    logic [9:0]  y;
    logic [3:0]  color;
    logic        mirror_x;
    logic        mirror_y;
    logic        last;
} t_tile_cmd;

// Expands every transferred entry into the tile commands it should produce and
// matches them, in order, against the commands the block emits.
class tile_cmd_tracker;
    t_tile_cmd tiles_due[$];
    int        errors           = 0;
    int        entries_seen     = 0;
    int        entries_expanded = 0;
    int        tiles_checked    = 0;
    bit [7:0]  kinds_hit        = '0;

    function int outstanding();
        return tiles_due.size();
    endfunction

    function void entry_accepted(t_entry e);
        logic [13:0] base;
        logic [8:0]  bx, by;
        logic        fx, fy;
        t_kind       kind;
        int          count;
        logic [3:0]  idx, k, off, last_idx;
        logic [1:0]  dx, dy;
        t_tile_cmd   cmd;
        entries_seen++;
        if (e.attr[7:4] != e.pass_pri || !e.attr[2]) return;
        fx    = e.attr[0];
        fy    = e.attr[1];
        kind  = K_ONE;
        count = 0;
        // size nibble: {height code, width code}; any zero code means an 8-pixel side
        case (e.size_color[3:0])
            4'd5:  begin kind = K_ONE;    count = 1;  end
            4'd6:  begin kind = K_LINE_H; count = 2;  end
            4'd7:  begin kind = K_LINE_H; count = 4;  end
            4'd9:  begin kind = K_LINE_V; count = 2;  end
            4'd13: begin kind = K_LINE_V; count = 4;  end
            4'd10: begin kind = K_SQ32;   count = 4;  end
            4'd11: begin kind = K_WIDE;   count = 8;  end
            4'd14: begin kind = K_TALL;   count = 8;  end
            4'd15: begin kind = K_SQ64;   count = 16; end
            default: count = 0;
        endcase
        if (count == 0) return;
        entries_expanded++;
        kinds_hit[int'(kind)] = 1'b1;
        base     = {e.code_hi, e.code_lo[7:2]};
        bx       = {e.x_hi[0], e.x_lo};
        by       = {e.y_hi[0], e.y_lo};
        last_idx = 4'(count - 1);
        for (int i = 0; i < count; i++) begin
            idx = i[3:0];
            k   = idx;
            off = '0;
            dx  = '0;
            dy  = '0;
            // 2-D code tables reduce to an XOR of the sub-tile index with a flip mask
            case (kind)
                K_LINE_H: begin
                    k   = fx ? last_idx - idx : idx;
                    off = k;
                    dx  = k[1:0];
                end
                K_LINE_V: begin
                    k   = fy ? last_idx - idx : idx;
                    off = k;
                    dy  = k[1:0];
                end
                K_SQ32: begin
                    off = idx ^ {2'b00, fy, fx};
                    dx  = {1'b0, idx[0]};
                    dy  = {1'b0, idx[1]};
                end
                K_WIDE: begin
                    off = idx ^ {1'b0, fy, fy, fx};
                    dx  = {idx[2], idx[0]};
                    dy  = {1'b0, idx[1]};
                end
                K_TALL: begin
                    off = idx ^ {1'b0, fx, fy, fx};
                    dx  = {1'b0, idx[0]};
                    dy  = idx[2:1];
                end
                K_SQ64: begin
                    off = idx ^ {fy, fx, fy, fx};
                    dx  = {idx[2], idx[0]};
                    dy  = {idx[3], idx[1]};
                end
                default: ;
            endcase
            cmd.code     = {1'b0, base} + {11'd0, off};
            cmd.x        = {1'b0, bx} + {4'd0, dx, 4'd0};
            cmd.y        = {1'b0, by} + {4'd0, dy, 4'd0};
            cmd.color    = e.size_color[7:4];
            cmd.mirror_x = fx;
            cmd.mirror_y = fy;
            cmd.last     = (i == count - 1);
            tiles_due.push_back(cmd);
        end
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            errors++;
        end
    endfunction

    function void tile_seen(t_tile_cmd got);
        t_tile_cmd want;
        tiles_checked++;
        if (tiles_due.size() == 0) begin
            $error("tile command with nothing expected: code %0d x %0d y %0d",
                   got.code, got.x, got.y);
            errors++;
            return;
        end
        want = tiles_due.pop_front();
        compare("tile_code", 32'(want.code), 32'(got.code));
        compare("pos_x", 32'(want.x), 32'(got.x));
        compare("pos_y", 32'(want.y), 32'(got.y));
        compare("colour", 32'(want.color), 32'(got.color));
        compare("mirror_x", 32'(want.mirror_x), 32'(got.mirror_x));
        compare("mirror_y", 32'(want.mirror_y), 32'(got.mirror_y));
        compare("last_tile", 32'(want.last), 32'(got.last));
    endfunction
endclass

module sprite_entry_tile_expander_test;

    // Random part: number of well-formed entries, and where idling stops
    localparam int RANDOM_ENTRIES = 230;
    localparam int IDLE_STOP      = RANDOM_ENTRIES - 60;
    // Longest stretch with no transfer on either side before the run is declared hung.
    // A correct run never comes near it (a hold_off gap, or a full queue behind a
    // 16-tile entry while tiles keep flowing), so this is far beyond any legal pause.
    localparam int WATCHDOG_LIMIT = 1000;
    // Quiet cycles after the last expected tile, to catch stray strobes
    localparam int SETTLE_CYCLES  = 24;
    localparam int ENTRY_W        = $bits(t_entry);

    // Size nibbles that expand to tiles, and ones with an 8-pixel side
    localparam logic [3:0] KEPT_SIZES [9] = '{4'd5, 4'd6, 4'd7, 4'd9, 4'd13,
                                              4'd10, 4'd11, 4'd14, 4'd15};
    localparam logic [3:0] NARROW_SIZES [7] = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd8, 4'd12};

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [3:0]  i_pass_priority;
    logic [7:0]  i_attr_byte;
    logic [7:0]  i_code_low_byte;
    logic [7:0]  i_code_high_byte;
    logic [7:0]  i_size_color_byte;
    logic [7:0]  i_y_low_byte;
    logic [7:0]  i_y_high_byte;
    logic [7:0]  i_x_low_byte;
    logic [7:0]  i_x_high_byte;
    logic        o_strobe;
    logic [14:0] o_tile_code;
    logic [9:0]  o_pos_x;
    logic [9:0]  o_pos_y;
    logic [3:0]  o_colour;
    logic        o_mirror_x;
    logic        o_mirror_y;
    logic        o_last_tile;

    tile_cmd_tracker tracker = new();
    int              quiet_cycles = 0;

    sprite_entry_tile_expander u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_pass_priority   (i_pass_priority),
        .i_attr_byte       (i_attr_byte),
        .i_code_low_byte   (i_code_low_byte),
        .i_code_high_byte  (i_code_high_byte),
        .i_size_color_byte (i_size_color_byte),
        .i_y_low_byte      (i_y_low_byte),
        .i_y_high_byte     (i_y_high_byte),
        .i_x_low_byte      (i_x_low_byte),
        .i_x_high_byte     (i_x_high_byte),
        .o_strobe          (o_strobe),
        .o_tile_code       (o_tile_code),
        .o_pos_x           (o_pos_x),
        .o_pos_y           (o_pos_y),
        .o_colour          (o_colour),
        .o_mirror_x        (o_mirror_x),
        .o_mirror_y        (o_mirror_y),
        .o_last_tile       (o_last_tile)
    );

    // 4 ns clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge, while the inputs set up
    // at the previous falling edge are stable and the block's registered outputs
    // still hold their pre-edge values.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_tile_cmd seen;
        t_entry    taken;
        if (i_rst_n) begin
            // tiles first; a new entry never yields a tile on its own transfer edge
            if (o_strobe !== 1'b0) begin
                seen.code     = o_tile_code;
                seen.x        = o_pos_x;
                seen.y        = o_pos_y;
                seen.color    = o_colour;
                seen.mirror_x = o_mirror_x;
                seen.mirror_y = o_mirror_y;
                seen.last     = o_last_tile;
                tracker.tile_seen(seen);
            end
            if (start && !busy) begin
                taken.pass_pri   = i_pass_priority;
                taken.attr       = i_attr_byte;
                taken.code_lo    = i_code_low_byte;
                taken.code_hi    = i_code_high_byte;
                taken.size_color = i_size_color_byte;
                taken.y_lo       = i_y_low_byte;
                taken.y_hi       = i_y_high_byte;
                taken.x_lo       = i_x_low_byte;
                taken.x_hi       = i_x_high_byte;
                tracker.entry_accepted(taken);
            end
            // watchdog: any transfer in either direction resets it
            if ((start && !busy) || o_strobe === 1'b1) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles, %0d tiles still due",
                         quiet_cycles, tracker.outstanding());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driving: all inputs change on the falling edge only.
    // ------------------------------------------------------------------------
    task automatic drive_fields(input t_entry e);
        i_pass_priority   <= e.pass_pri;
        i_attr_byte       <= e.attr;
        i_code_low_byte   <= e.code_lo;
        i_code_high_byte  <= e.code_hi;
        i_size_color_byte <= e.size_color;
        i_y_low_byte      <= e.y_lo;
        i_y_high_byte     <= e.y_hi;
        i_x_low_byte      <= e.x_lo;
        i_x_high_byte     <= e.x_hi;
    endtask

    // Fully random entry bits.
    function automatic t_entry random_entry();
        logic [95:0] r;
        r = {$urandom, $urandom, $urandom};
        return r[ENTRY_W-1:0];
    endfunction

    // Present one entry and hold it until the block takes it (busy low at the edge).
    // start stays high on return, so back-to-back entries go out without a gap.
    task automatic send_entry(input t_entry e);
        @(negedge i_clk);
        start <= 1'b1;
        drive_fields(e);
        do @(posedge i_clk); while (busy);
    endtask

    // Idle with junk on the entry fields; start low must mask it.
    task automatic hold_off(input int n);
        t_entry junk;
        repeat (n) begin
            @(negedge i_clk);
            junk = random_entry();
            start <= 1'b0;
            drive_fields(junk);
        end
    endtask

    task automatic wait_for_tiles();
        while (tracker.outstanding() != 0) @(posedge i_clk);
    endtask

    // Visible entry of the current pass with the given size and flips; rest random.
    function automatic t_entry shaped_entry(input logic [3:0] size, input logic [1:0] flip);
        t_entry e;
        e                  = random_entry();
        e.attr[2]          = 1'b1;
        e.attr[1:0]        = flip;
        e.pass_pri         = e.attr[7:4];
        e.size_color[3:0]  = size;
        return e;
    endfunction

    function automatic logic [3:0] any_kept_size();
        return KEPT_SIZES[$urandom_range(0, 8)];
    endfunction

    // Entry that should be dropped (or, for the last flavor, anything at all)
    function automatic t_entry broken_entry();
        t_entry     e;
        logic [3:0] other;
        e     = shaped_entry(any_kept_size(), 2'($urandom_range(0, 3)));
        other = 4'($urandom_range(1, 15));
        case ($urandom_range(0, 3))
            0: e.attr[2] = 1'b0;                              // hidden
            1: e.pass_pri = e.attr[7:4] ^ other;              // another pass
            2: e.size_color[3:0] = NARROW_SIZES[$urandom_range(0, 6)];
            default: e = random_entry();
        endcase
        return e;
    endfunction

    // ------------------------------------------------------------------------
    // Directed part: field extremes, every size kind, flips, and the drop cases
    // ------------------------------------------------------------------------
    task automatic run_directed();
        t_entry e;
        // all-zero single tile, pass 0
        e = '0;
        e.attr       = 8'h04;
        e.size_color = 8'h05;
        send_entry(e);
        // everything at its top value: 64x64, both flips, max code and positions,
        // unused high bits of the position bytes set
        e = '1;
        e.attr[3] = 1'b0;
        send_entry(e);
        // every expanding size once, flips rotating
        for (int i = 0; i < 9; i++) send_entry(shaped_entry(KEPT_SIZES[i], i[1:0]));
        // rows and columns: flip along the axis reverses, across it does not
        send_entry(shaped_entry(4'd7, 2'b01));
        send_entry(shaped_entry(4'd7, 2'b10));
        send_entry(shaped_entry(4'd13, 2'b10));
        send_entry(shaped_entry(4'd13, 2'b01));
        // 8-pixel sides produce nothing
        send_entry(shaped_entry(4'd0, 2'b00));
        send_entry(shaped_entry(4'd1, 2'b11));
        send_entry(shaped_entry(4'd4, 2'b01));
        send_entry(shaped_entry(4'd12, 2'b10));
        // hidden entry of the right pass
        e = shaped_entry(4'd15, 2'b00);
        e.attr[2] = 1'b0;
        send_entry(e);
        // visible entry of another pass
        e = shaped_entry(4'd15, 2'b11);
        e.pass_pri = ~e.attr[7:4];
        send_entry(e);
        hold_off(3);
    endtask

    // ------------------------------------------------------------------------
    // Random part: mostly well-formed entries with random content, about one in
    // five dropped or garbage. Random gaps until the last stretch, which runs
    // back to back; one full drain halfway through.
    // ------------------------------------------------------------------------
    task automatic run_random();
        int shaped;
        shaped = 0;
        while (shaped < RANDOM_ENTRIES) begin
            if ($urandom_range(0, 4) == 0) begin
                send_entry(broken_entry());
            end else begin
                send_entry(shaped_entry(any_kept_size(), 2'($urandom_range(0, 3))));
                shaped++;
                if (shaped == RANDOM_ENTRIES / 2) begin
                    // let the queue and the back end run dry before carrying on
                    hold_off(1);
                    wait_for_tiles();
                end
            end
            if (shaped < IDLE_STOP && $urandom_range(0, 3) == 0) begin
                hold_off($urandom_range(1, 8));
            end
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        start             = 1'b0;
        i_pass_priority   = '0;
        i_attr_byte       = '0;
        i_code_low_byte   = '0;
        i_code_high_byte  = '0;
        i_size_color_byte = '0;
        i_y_low_byte      = '0;
        i_y_high_byte     = '0;
        i_x_low_byte      = '0;
        i_x_high_byte     = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        run_random();
        hold_off(1);

        // all tiles in, then a quiet stretch to catch anything extra
        wait_for_tiles();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d entries (%0d expanded, %0d dropped), %0d tile commands checked",
                 tracker.entries_seen, tracker.entries_expanded,
                 tracker.entries_seen - tracker.entries_expanded, tracker.tiles_checked);
        $display("Size kinds exercised: %0d of 7, with random flips, gaps and back-pressure",
                 $countones(tracker.kinds_hit));
        if (tracker.errors == 0 && tracker.outstanding() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
